FILE: hdl/rttmd_pkg.sv
// ----------------------------------------------------------------------------
// rttmd_pkg
// Shared widths and state encoding for the round-trip-time statistics block.
// ----------------------------------------------------------------------------
package rttmd_pkg;

   localparam int CNT_W      = 16;   // sample count
   localparam int SUM_W      = 48;   // sum of times
   localparam int SQS_W      = 63;   // sum of squares
   localparam int RES_W      = 32;   // mean and deviation
   localparam int REQ_DATA_W = 128;  // count, time sum, square sum, zero pad
   localparam int RSP_DATA_W = 64;   // mean, deviation

   localparam int DIV_W      = SQS_W;              // dividend and quotient width
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int RAD_W      = 2 * RES_W;          // radicand width
   localparam int ROOT_CNT_W = $clog2(RES_W);
   localparam int PRT_REM_W  = RES_W + 1;          // partial remainder of the root

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TIME,
      ST_DIV_SQUARE,
      ST_SQUARE,
      ST_DIFF,
      ST_ROOT,
      ST_FINISH
   } state_type;

endpackage

FILE: hdl/rtt_mean_and_deviation.sv
// A zero count skips the divider and square root and goes straight to ST_FINISH.
// A new request is accepted only in ST_IDLE, after the last one has passed the
//   bit-serial divider, run twice, and the 32-step serial square root.
// A result waiting on rsp_tready does not block the next request from entering.
// Reset (synchronous, active high) returns the sequencer to idle and empties
//   the result register.
// ----------------------------------------------------------------------------
// rtt_mean_and_deviation
// Mean and standard deviation of round-trip times from count, sum and sum of
// squares, using a shared serial divider and a serial square root.
// ----------------------------------------------------------------------------
module rtt_mean_and_deviation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_count [15:0], time_sum [63:16], square_sum [126:64], zero [127]
   input  logic [rttmd_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mean_time [31:0], deviation [63:32]
   output logic [rttmd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // valid_res [0]
   output logic                              rsp_tuser
);
   import rttmd_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SQS_W-1:0]     sqs_ff, sqs_in;
   logic [SUM_W-1:0]     mean_ff, mean_in;
   logic [DIV_W-1:0]     msq_ff, msq_in;
   logic [RAD_W-1:0]     prod_ff, prod_in;
   logic                 big_ff, big_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic [CNT_W-1:0]     req_count;
   logic [SUM_W-1:0]     req_time;
   logic [SQS_W-1:0]     req_sqs;

   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [CNT_W-1:0]     div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;

   logic                 root_start;
   logic [RAD_W-1:0]     radicand;
   logic                 root_done;
   logic [RES_W-1:0]     root;

   logic [RAD_W-1:0]     msq_ext;
   logic [RES_W-1:0]     mean_lo;
   logic [RES_W-1:0]     mean_sat;

   assign req_count = req_tdata[CNT_W-1:0];
   assign req_time  = req_tdata[CNT_W +: SUM_W];
   assign req_sqs   = req_tdata[CNT_W+SUM_W +: SQS_W];

   rttmd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rttmd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      msq_ext  = {{(RAD_W-DIV_W){1'b0}}, msq_ff};
      mean_lo  = mean_ff[RES_W-1:0];
      mean_sat = big_ff ? '1 : mean_lo;
      radicand = (big_ff || (prod_ff > msq_ext)) ? '0 : msq_ext - prod_ff;

      state_in     = state_ff;
      count_in     = count_ff;
      sqs_in       = sqs_ff;
      mean_in      = mean_ff;
      msq_in       = msq_ff;
      prod_in      = prod_ff;
      big_in       = big_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = sqs_ff;
      div_divisor  = count_ff;
      root_start   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               count_in = req_count;
               sqs_in   = req_sqs;
               if (req_count == '0) begin
                  zero_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  zero_in      = 1'b0;
                  div_start    = 1'b1;
                  div_dividend = {{(DIV_W-SUM_W){1'b0}}, req_time};
                  div_divisor  = req_count;
                  state_in     = ST_DIV_TIME;
               end
            end
         end
         ST_DIV_TIME: begin
            if (div_done) begin
               mean_in   = div_quotient[SUM_W-1:0];
               div_start = 1'b1;
               state_in  = ST_DIV_SQUARE;
            end
         end
         ST_DIV_SQUARE: begin
            if (div_done) begin
               msq_in   = div_quotient;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            prod_in  = RAD_W'(mean_lo) * RAD_W'(mean_lo);
            big_in   = |mean_ff[SUM_W-1:RES_W];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = !zero_ff;
               rsp_data_in  = zero_ff ? '0 : {root, mean_sat};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      sqs_ff      <= sqs_in;
      mean_ff     <= mean_in;
      msq_ff      <= msq_in;
      prod_ff     <= prod_in;
      big_ff      <= big_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: hdl/rttmd_divider.sv
// ----------------------------------------------------------------------------
// rttmd_divider
// Bit-serial restoring divider: one quotient bit per cycle, DIV_W quotient bits.
// ----------------------------------------------------------------------------
module rttmd_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rttmd_pkg::DIV_W-1:0]    dividend,
   input  logic [rttmd_pkg::CNT_W-1:0]    divisor,
   output logic                           done,
   output logic [rttmd_pkg::DIV_W-1:0]    quotient
);
   import rttmd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [CNT_W:0]       shifted;
   logic [CNT_W:0]       diff;
   logic                 fits;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIV_W-1]};
      diff     = shifted - {1'b0, dsr_ff};
      fits     = shifted >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dsr_in   = divisor;
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/rttmd_sqrt.sv
// ----------------------------------------------------------------------------
// rttmd_sqrt
// Digit-serial floor square root: two radicand bits in, one root bit out
// per cycle.
// ----------------------------------------------------------------------------
module rttmd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rttmd_pkg::RAD_W-1:0]    radicand,
   output logic                           done,
   output logic [rttmd_pkg::RES_W-1:0]    root
);
   import rttmd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] count_ff, count_in;
   logic [RAD_W-1:0]      val_ff, val_in;
   logic [PRT_REM_W-1:0]  rem_ff, rem_in;
   logic [RES_W-1:0]      root_ff, root_in;
   logic [PRT_REM_W+1:0]  shifted;
   logic [PRT_REM_W+1:0]  trial;
   logic [PRT_REM_W+1:0]  diff;
   logic                  fits;

   always_comb begin
      shifted  = {rem_ff, val_ff[RAD_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      diff     = shifted - trial;
      fits     = shifted >= trial;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         val_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         val_in   = {val_ff[RAD_W-3:0], 2'b00};
         rem_in   = fits ? diff[PRT_REM_W-1:0] : shifted[PRT_REM_W-1:0];
         root_in  = {root_ff[RES_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == ROOT_CNT_W'(RES_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
